// ===== rtl/core/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

    localparam logic [4:0] KIND_IDENT  = 5'd16;
    localparam logic [4:0] KIND_NUMBER = 5'd17;
    localparam logic [4:0] KIND_ASSIGN = 5'd18;
    localparam logic [4:0] KIND_PLUS   = 5'd19;
    localparam logic [4:0] KIND_MINUS  = 5'd20;
    localparam logic [4:0] KIND_TIMES  = 5'd21;
    localparam logic [4:0] KIND_DIVIDE = 5'd22;
    localparam logic [4:0] KIND_MOD    = 5'd23;
    localparam logic [4:0] KIND_NOT    = 5'd24;
    localparam logic [4:0] KIND_SEMI   = 5'd25;
    localparam logic [4:0] KIND_COMMA  = 5'd26;
    localparam logic [4:0] KIND_LPAREN = 5'd27;
    localparam logic [4:0] KIND_RPAREN = 5'd28;
    localparam logic [4:0] KIND_OTHER  = 5'd30;
    localparam logic [4:0] KIND_NONE   = 5'd0;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_IDENT = 3'd1;
    localparam logic [2:0] ERR_RANGE     = 3'd2;
    localparam logic [2:0] ERR_WORD      = 3'd3;
    localparam logic [2:0] ERR_CHAR      = 3'd4;
    localparam logic [2:0] ERR_EOF       = 3'd5;

    localparam logic [14:0] NUM_LIMIT = 15'd32767;
    localparam logic [5:0]  LEN_LIMIT = 6'd63;
    localparam int          KW_COUNT  = 16;
    localparam int          KW_MAX    = 12;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_WORD,
        MODE_NUMBER,
        MODE_COMMENT,
        MODE_SLASH,
        MODE_COLON
    } scan_mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [14:0] number_value;
        logic [31:0] text;
        logic [5:0]  length;
        logic [2:0]  err;
        logic        last;
    } tok_t;

    typedef struct packed {
        tok_t       tok0;
        tok_t       tok1;
        logic [1:0] count;
    } step_out_t;

    typedef struct packed {
        logic       step_ready;
        logic [1:0] count;
    } queue_status_t;

    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd12, 8'd8, 8'd9, 8'd7, 8'd2, 8'd4, 8'd5, 8'd3,
        8'd3, 8'd5, 8'd2, 8'd5, 8'd4, 8'd2, 8'd3, 8'd2
    };

    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        "startprogram", "variable", "startblok", "endblok", "if", "else", "while",
        "get", "put", "int_2", "eq", "noteq", "less", "gr", "and", "or"
    };

    function automatic logic [7:0] kw_char(input int k, input int i);
        logic [7:0] ch;
        ch = 8'd0;
        if (i < int'(KW_LEN[k]))
        begin
            ch = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
        end
        return ch;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_TIMES;
            8'h25:   k = KIND_MOD;
            8'h21:   k = KIND_NOT;
            8'h3B:   k = KIND_SEMI;
            8'h2C:   k = KIND_COMMA;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic tok_t make_tok(
        input logic [4:0]  kind,
        input logic [15:0] line,
        input logic [15:0] column,
        input logic [14:0] number_value,
        input logic [31:0] text,
        input logic [5:0]  length,
        input logic [2:0]  err
    );
        tok_t t;
        t.kind         = kind;
        t.line         = line;
        t.column       = column;
        t.number_value = number_value;
        t.text         = text;
        t.length       = length;
        t.err          = err;
        t.last         = 1'b1;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stt_if.sv =====
`default_nettype none

interface stt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface stt_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [14:0] number_value;
    logic [31:0] token_text;
    logic [5:0]  text_length;
    logic [2:0]  error_code;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output token_line, output token_column,
        output number_value, output token_text, output text_length, output error_code,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_line, input token_column,
        input number_value, input token_text, input text_length, input error_code,
        input last_of_run, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/stt_scanner.sv =====
`default_nettype none

module stt_scanner #(
    parameter int MAX_KEYWORD_LEN = 12,
    parameter int POSITION_BITS   = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        char_byte,
    input  wire logic              end_of_input,
    output stt_pkg::step_out_t     result
);

    localparam int IDX_W = $clog2(MAX_KEYWORD_LEN);

    stt_pkg::scan_mode_t      mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [7:0]               buf_reg [MAX_KEYWORD_LEN];
    logic [5:0]               wlen_reg, wlen_next;
    logic [14:0]              acc_reg, acc_next;
    logic                     big_reg, big_next;

    logic        eof;
    logic        store_en;
    logic [5:0]  store_base;
    logic        move;
    logic        done;
    logic        ph1_v, ph2_v;
    stt_pkg::tok_t ph1_tok, ph2_tok;
    logic [15:0] line16, col16, start16;
    logic [31:0] word_text, ident_text;
    logic [5:0]  letters;
    logic        kw_hit;
    logic [4:0]  kw_idx;
    logic [18:0] acc_prod;
    logic        word_ch;
    logic [4:0]  op;

    assign eof     = end_of_input || (char_byte == 8'd0);
    assign line16  = 16'(line_reg);
    assign col16   = 16'(col_reg);
    assign start16 = 16'(start_reg);
    assign letters = (wlen_reg != 6'd0) ? wlen_reg - 6'd1 : 6'd0;
    assign acc_prod = 19'(acc_reg) * 19'd10 + 19'(char_byte[3:0]);
    assign word_ch = stt_pkg::is_upper(char_byte) || stt_pkg::is_lower(char_byte)
                     || stt_pkg::is_digit(char_byte) || (char_byte == 8'h5F);
    assign op = stt_pkg::op_kind(char_byte);

    always_comb
    begin
        word_text  = '0;
        ident_text = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (6'(i) < wlen_reg)
            begin
                word_text[8*i +: 8] = buf_reg[i];
            end
            if (6'(i) < letters)
            begin
                ident_text[8*i +: 8] = buf_reg[i+1];
            end
        end
    end

    always_comb
    begin
        logic match;
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            match = (wlen_reg == 6'(stt_pkg::KW_LEN[k]))
                    && (int'(stt_pkg::KW_LEN[k]) <= MAX_KEYWORD_LEN);
            for (int i = 0; i < MAX_KEYWORD_LEN; i++)
            begin
                if ((i < int'(stt_pkg::KW_LEN[k])) && (buf_reg[i] != stt_pkg::kw_char(k, i)))
                begin
                    match = 1'b0;
                end
            end
            if (match)
            begin
                kw_hit = 1'b1;
                kw_idx = 5'(k);
            end
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        wlen_next  = wlen_reg;
        acc_next   = acc_reg;
        big_next   = big_reg;
        store_en   = 1'b0;
        store_base = wlen_reg;
        move       = 1'b0;
        done       = 1'b0;
        ph1_v      = 1'b0;
        ph2_v      = 1'b0;
        ph1_tok    = '0;
        ph2_tok    = '0;

        unique case (mode_reg)
            stt_pkg::MODE_IDENT:
            begin
                if (!eof && stt_pkg::is_upper(char_byte))
                begin
                    store_en = 1'b1;
                    move     = 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    ph1_v = 1'b1;
                    if ((letters >= 6'd1) && (letters <= 6'd4))
                    begin
                        ph1_tok = stt_pkg::make_tok(stt_pkg::KIND_IDENT, line16, start16, '0,
                                                    ident_text, wlen_reg, stt_pkg::ERR_NONE);
                    end
                    else
                    begin
                        ph1_tok = stt_pkg::make_tok(stt_pkg::KIND_OTHER, line16, start16, '0,
                                                    ident_text, wlen_reg,
                                                    stt_pkg::ERR_BAD_IDENT);
                    end
                end
            end
            stt_pkg::MODE_WORD:
            begin
                if (!eof && word_ch)
                begin
                    store_en = 1'b1;
                    move     = 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    ph1_v = 1'b1;
                    if (kw_hit)
                    begin
                        ph1_tok = stt_pkg::make_tok(kw_idx, line16, start16, '0, word_text,
                                                    wlen_reg, stt_pkg::ERR_NONE);
                    end
                    else
                    begin
                        ph1_tok = stt_pkg::make_tok(stt_pkg::KIND_OTHER, line16, start16, '0,
                                                    word_text, wlen_reg, stt_pkg::ERR_WORD);
                    end
                end
            end
            stt_pkg::MODE_NUMBER:
            begin
                if (!eof && stt_pkg::is_digit(char_byte))
                begin
                    if (acc_prod > 19'(stt_pkg::NUM_LIMIT))
                    begin
                        acc_next = stt_pkg::NUM_LIMIT;
                        big_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_prod[14:0];
                    end
                    if (wlen_reg < stt_pkg::LEN_LIMIT)
                    begin
                        wlen_next = wlen_reg + 6'd1;
                    end
                    move = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    ph1_v   = 1'b1;
                    ph1_tok = stt_pkg::make_tok(stt_pkg::KIND_NUMBER, line16, start16, acc_reg,
                                                '0, wlen_reg,
                                                big_reg ? stt_pkg::ERR_RANGE : stt_pkg::ERR_NONE);
                end
            end
            stt_pkg::MODE_COMMENT:
            begin
                if (!eof && (char_byte != 8'h0A))
                begin
                    move = 1'b1;
                    done = 1'b1;
                end
            end
            stt_pkg::MODE_SLASH:
            begin
                if (!eof && (char_byte == 8'h2A))
                begin
                    mode_next = stt_pkg::MODE_COMMENT;
                    move      = 1'b1;
                    done      = 1'b1;
                end
                else
                begin
                    ph1_v   = 1'b1;
                    ph1_tok = stt_pkg::make_tok(stt_pkg::KIND_DIVIDE, line16, start16, '0,
                                                32'h2F, 6'd1, stt_pkg::ERR_NONE);
                end
            end
            stt_pkg::MODE_COLON:
            begin
                ph1_v = 1'b1;
                if (!eof && (char_byte == 8'h3A))
                begin
                    ph1_tok   = stt_pkg::make_tok(stt_pkg::KIND_ASSIGN, line16, start16, '0,
                                                  32'h3A3A, 6'd2, stt_pkg::ERR_NONE);
                    mode_next = stt_pkg::MODE_IDLE;
                    move      = 1'b1;
                    done      = 1'b1;
                end
                else
                begin
                    ph1_tok = stt_pkg::make_tok(stt_pkg::KIND_OTHER, line16, start16, '0,
                                                32'h3A, 6'd1, stt_pkg::ERR_CHAR);
                end
            end
            default:
            begin
            end
        endcase

        if (!done)
        begin
            mode_next = stt_pkg::MODE_IDLE;
            if (eof)
            begin
                ph2_v   = 1'b1;
                ph2_tok = stt_pkg::make_tok(stt_pkg::KIND_OTHER, line16, col16, '0, '0, '0,
                                            stt_pkg::ERR_EOF);
            end
            else if (stt_pkg::is_space(char_byte))
            begin
                move = 1'b1;
            end
            else if ((char_byte == 8'h5F) || stt_pkg::is_upper(char_byte)
                     || stt_pkg::is_lower(char_byte))
            begin
                start_next = col_reg;
                store_en   = 1'b1;
                store_base = 6'd0;
                mode_next  = (char_byte == 8'h5F) ? stt_pkg::MODE_IDENT : stt_pkg::MODE_WORD;
                move       = 1'b1;
            end
            else if (stt_pkg::is_digit(char_byte))
            begin
                start_next = col_reg;
                acc_next   = 15'(char_byte[3:0]);
                big_next   = 1'b0;
                wlen_next  = 6'd1;
                mode_next  = stt_pkg::MODE_NUMBER;
                move       = 1'b1;
            end
            else if ((char_byte == 8'h2F) || (char_byte == 8'h3A))
            begin
                start_next = col_reg;
                mode_next  = (char_byte == 8'h2F) ? stt_pkg::MODE_SLASH : stt_pkg::MODE_COLON;
                move       = 1'b1;
            end
            else
            begin
                ph2_v = 1'b1;
                if (op != stt_pkg::KIND_NONE)
                begin
                    ph2_tok = stt_pkg::make_tok(op, line16, col16, '0, 32'(char_byte), 6'd1,
                                                stt_pkg::ERR_NONE);
                end
                else
                begin
                    ph2_tok = stt_pkg::make_tok(stt_pkg::KIND_OTHER, line16, col16, '0,
                                                32'(char_byte), 6'd1, stt_pkg::ERR_CHAR);
                end
                move = 1'b1;
            end
        end

        if (store_en)
        begin
            wlen_next = (store_base < stt_pkg::LEN_LIMIT) ? store_base + 6'd1 : store_base;
        end

        if (move)
        begin
            if (char_byte == 8'h0A)
            begin
                if (line_reg != '1)
                begin
                    line_next = line_reg + 1'b1;
                end
                col_next = POSITION_BITS'(1);
            end
            else if (col_reg != '1)
            begin
                col_next = col_reg + 1'b1;
            end
        end

        if (!done && eof)
        begin
            line_next  = POSITION_BITS'(1);
            col_next   = POSITION_BITS'(1);
            start_next = POSITION_BITS'(1);
        end
    end

    always_comb
    begin
        result.tok0  = ph1_v ? ph1_tok : ph2_tok;
        result.tok1  = ph2_tok;
        result.count = 2'(ph1_v) + 2'(ph2_v);
        result.tok0.last = !(ph1_v && ph2_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stt_pkg::MODE_IDLE;
            line_reg  <= POSITION_BITS'(1);
            col_reg   <= POSITION_BITS'(1);
            start_reg <= POSITION_BITS'(1);
            wlen_reg  <= '0;
            acc_reg   <= '0;
            big_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            wlen_reg  <= wlen_next;
            acc_reg   <= acc_next;
            big_reg   <= big_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && store_en && (32'(store_base) < MAX_KEYWORD_LEN))
        begin
            buf_reg[store_base[IDX_W-1:0]] <= char_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stt_out_queue.sv =====
`default_nettype none

module stt_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire stt_pkg::step_out_t   step_result,
    input  wire logic                 pop_ready,
    output stt_pkg::tok_t             head,
    output logic                      head_valid,
    output stt_pkg::queue_status_t    status
);

    stt_pkg::tok_t q_reg [2];
    logic [1:0]    count_reg, count_next;
    logic          pop;

    assign head_valid        = (count_reg != 2'd0);
    assign head              = q_reg[0];
    assign pop               = head_valid && pop_ready;
    assign status.step_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop_ready);
    assign status.count      = count_reg;

    // A push only happens when the queue is empty or drains empty in the same cycle.
    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = step_result.count;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[0] <= step_result.tok0;
            q_reg[1] <= step_result.tok1;
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/source_text_tokenizer.sv =====
// Latency: a token appears on token_out the cycle after the byte that completes it.
// Throughput: one byte per cycle while token_out is ready; a byte that yields two tokens holds
// off char_in until the two-entry result queue is down to one entry that is being taken.
// Reset (rst_n, asynchronous, active low): scanning idle at line 1, column 1, queue empty.
`default_nettype none

module source_text_tokenizer #(
    parameter int MAX_KEYWORD_LEN = 12,
    parameter int POSITION_BITS   = 16
) (
    input wire logic      clk,
    input wire logic      rst_n,
    stt_char_if.sink      char_in,
    stt_token_if.source   token_out
);

    stt_pkg::step_out_t     step_result;
    stt_pkg::queue_status_t q_status;
    stt_pkg::tok_t          head;
    logic                   head_valid;
    logic                   step;

    assign char_in.ready = q_status.step_ready;
    assign step          = char_in.valid && q_status.step_ready;

    stt_scanner #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .POSITION_BITS   (POSITION_BITS)
    ) u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_byte    (char_in.char_byte),
        .end_of_input (char_in.end_of_input),
        .result       (step_result)
    );

    stt_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (step),
        .step_result (step_result),
        .pop_ready   (token_out.ready),
        .head        (head),
        .head_valid  (head_valid),
        .status      (q_status)
    );

    assign token_out.valid        = head_valid;
    assign token_out.token_kind   = head.kind;
    assign token_out.token_line   = head.line;
    assign token_out.token_column = head.column;
    assign token_out.number_value = head.number_value;
    assign token_out.token_text   = head.text;
    assign token_out.text_length  = head.length;
    assign token_out.error_code   = head.err;
    assign token_out.last_of_run  = head.last;

    a_two_tokens_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (step_result.count == 2'd2)) |=> !char_in.ready)
        else $error("two-token step did not hold off the next byte");

    a_second_token_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (token_out.valid && token_out.ready && !token_out.last_of_run) |=> token_out.valid)
        else $error("second token of a step was lost");

    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (token_out.valid && (token_out.error_code == stt_pkg::ERR_EOF))
        |-> ((token_out.text_length == 6'd0) && token_out.last_of_run))
        else $error("end-of-file token malformed");

    a_number_only: assert property (@(posedge clk) disable iff (!rst_n)
        (token_out.valid && (token_out.number_value != 15'd0))
        |-> (token_out.token_kind == stt_pkg::KIND_NUMBER))
        else $error("number value on a non-number token");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    stt_char_if  char_bus ();
    stt_token_if tok_bus ();

    source_text_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_bus),
        .token_out (tok_bus)
    );

    stt_pkg::tok_t token_exp_q[$];
    int            error_count;
    int            tokens_seen;
    int            bytes_sent;
    int            hold_cycles;
    int            stall_left;

    stt_pkg::scan_mode_t p_mode;
    logic [15:0]         p_line;
    logic [15:0]         p_col;
    logic [15:0]         p_start;
    logic [7:0]          p_wbuf [12];
    logic [5:0]          p_wlen;
    int                  p_acc;
    logic                p_big;

    string kw_names [16] = '{
        "startprogram", "variable", "startblok", "endblok", "if", "else", "while",
        "get", "put", "int_2", "eq", "noteq", "less", "gr", "and", "or"
    };

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("source_text_tokenizer: mismatch");
        $finish;
    end

    function automatic logic upper_c(logic [7:0] c);
        return c >= 8'h41 && c <= 8'h5A;
    endfunction

    function automatic logic lower_c(logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7A;
    endfunction

    function automatic logic digit_c(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function void push_token(logic [4:0] k, logic [15:0] col, logic [14:0] num,
                             logic [31:0] txt, logic [5:0] len, logic [2:0] err);
        stt_pkg::tok_t t;
        t.kind = k;
        t.line = p_line;
        t.column = col;
        t.number_value = num;
        t.text = txt;
        t.length = len;
        t.err = err;
        t.last = 1'b0;
        token_exp_q.insert(token_exp_q.size(), t);
    endfunction

    function void advance_position(logic [7:0] c);
        if (c == 8'h0A)
        begin
            if (p_line != 16'hFFFF)
                p_line++;
            p_col = 16'd1;
        end
        else if (p_col != 16'hFFFF)
        begin
            p_col++;
        end
    endfunction

    function void store_letter(logic [7:0] c);
        if (p_wlen < 12)
            p_wbuf[p_wlen] = c;
        if (p_wlen < 63)
            p_wlen++;
    endfunction

    function logic [31:0] packed_letters(int from, int count);
        logic [31:0] t;
        t = '0;
        for (int i = 0; i < count && i < 4; i++)
            if (from + i < 12)
                t |= 32'(p_wbuf[from + i]) << (8 * i);
        return t;
    endfunction

    function void close_word();
        logic hit;
        int   k;
        hit = 1'b0;
        for (k = 0; k < 16 && !hit; k++)
        begin
            if (p_wlen == kw_names[k].len())
            begin
                hit = 1'b1;
                for (int i = 0; i < kw_names[k].len(); i++)
                    if (p_wbuf[i] != kw_names[k][i])
                        hit = 1'b0;
                if (hit)
                    push_token(5'(k), p_start, 0, packed_letters(0, p_wlen), p_wlen,
                               stt_pkg::ERR_NONE);
            end
        end
        if (!hit)
            push_token(stt_pkg::KIND_OTHER, p_start, 0, packed_letters(0, p_wlen), p_wlen,
                       stt_pkg::ERR_WORD);
    endfunction

    function void predict_tokens(logic [7:0] c, logic e);
        logic       eof;
        logic       done;
        int         prior_count;
        int         letters;
        logic [4:0] op;
        eof = e || c == 8'h00;
        done = 1'b0;
        prior_count = token_exp_q.size();
        case (p_mode)
            stt_pkg::MODE_IDENT:
            begin
                if (!eof && upper_c(c))
                begin
                    store_letter(c);
                    advance_position(c);
                    done = 1'b1;
                end
                else
                begin
                    letters = p_wlen > 0 ? p_wlen - 1 : 0;
                    if (letters >= 1 && letters <= 4)
                        push_token(stt_pkg::KIND_IDENT, p_start, 0, packed_letters(1, letters),
                                   p_wlen, stt_pkg::ERR_NONE);
                    else
                        push_token(stt_pkg::KIND_OTHER, p_start, 0, packed_letters(1, letters),
                                   p_wlen, stt_pkg::ERR_BAD_IDENT);
                end
            end
            stt_pkg::MODE_WORD:
            begin
                if (!eof && (upper_c(c) || lower_c(c) || digit_c(c) || c == 8'h5F))
                begin
                    store_letter(c);
                    advance_position(c);
                    done = 1'b1;
                end
                else
                begin
                    close_word();
                end
            end
            stt_pkg::MODE_NUMBER:
            begin
                if (!eof && digit_c(c))
                begin
                    p_acc = p_acc * 10 + (c - 8'h30);
                    if (p_acc > 32767)
                    begin
                        p_acc = 32767;
                        p_big = 1'b1;
                    end
                    if (p_wlen < 63)
                        p_wlen++;
                    advance_position(c);
                    done = 1'b1;
                end
                else
                begin
                    push_token(stt_pkg::KIND_NUMBER, p_start, 15'(p_acc), 0, p_wlen,
                               p_big ? stt_pkg::ERR_RANGE : stt_pkg::ERR_NONE);
                end
            end
            stt_pkg::MODE_COMMENT:
            begin
                if (!eof && c != 8'h0A)
                begin
                    advance_position(c);
                    done = 1'b1;
                end
            end
            stt_pkg::MODE_SLASH:
            begin
                if (!eof && c == 8'h2A)
                begin
                    p_mode = stt_pkg::MODE_COMMENT;
                    advance_position(c);
                    done = 1'b1;
                end
                else
                begin
                    push_token(stt_pkg::KIND_DIVIDE, p_start, 0, 32'h2F, 6'd1,
                               stt_pkg::ERR_NONE);
                end
            end
            stt_pkg::MODE_COLON:
            begin
                if (!eof && c == 8'h3A)
                begin
                    push_token(stt_pkg::KIND_ASSIGN, p_start, 0, 32'h3A3A, 6'd2,
                               stt_pkg::ERR_NONE);
                    p_mode = stt_pkg::MODE_IDLE;
                    advance_position(c);
                    done = 1'b1;
                end
                else
                begin
                    push_token(stt_pkg::KIND_OTHER, p_start, 0, 32'h3A, 6'd1, stt_pkg::ERR_CHAR);
                end
            end
            default:
            begin
            end
        endcase
        if (!done)
        begin
            p_mode = stt_pkg::MODE_IDLE;
            if (eof)
            begin
                push_token(stt_pkg::KIND_OTHER, p_col, 0, 0, 0, stt_pkg::ERR_EOF);
                p_line = 16'd1;
                p_col = 16'd1;
                p_start = 16'd1;
            end
            else if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13))
            begin
                advance_position(c);
            end
            else if (c == 8'h5F || upper_c(c) || lower_c(c))
            begin
                p_start = p_col;
                p_wlen = 0;
                store_letter(c);
                p_mode = (c == 8'h5F) ? stt_pkg::MODE_IDENT : stt_pkg::MODE_WORD;
                advance_position(c);
            end
            else if (digit_c(c))
            begin
                p_start = p_col;
                p_acc = c - 8'h30;
                p_big = 1'b0;
                p_wlen = 6'd1;
                p_mode = stt_pkg::MODE_NUMBER;
                advance_position(c);
            end
            else if (c == 8'h2F || c == 8'h3A)
            begin
                p_start = p_col;
                p_mode = (c == 8'h2F) ? stt_pkg::MODE_SLASH : stt_pkg::MODE_COLON;
                advance_position(c);
            end
            else
            begin
                case (c)
                    8'h2B:   op = stt_pkg::KIND_PLUS;
                    8'h2D:   op = stt_pkg::KIND_MINUS;
                    8'h2A:   op = stt_pkg::KIND_TIMES;
                    8'h25:   op = stt_pkg::KIND_MOD;
                    8'h21:   op = stt_pkg::KIND_NOT;
                    8'h3B:   op = stt_pkg::KIND_SEMI;
                    8'h2C:   op = stt_pkg::KIND_COMMA;
                    8'h28:   op = stt_pkg::KIND_LPAREN;
                    8'h29:   op = stt_pkg::KIND_RPAREN;
                    default: op = stt_pkg::KIND_NONE;
                endcase
                if (op != stt_pkg::KIND_NONE)
                    push_token(op, p_col, 0, 32'(c), 6'd1, stt_pkg::ERR_NONE);
                else
                    push_token(stt_pkg::KIND_OTHER, p_col, 0, 32'(c), 6'd1, stt_pkg::ERR_CHAR);
                advance_position(c);
            end
        end
        if (token_exp_q.size() > prior_count)
            token_exp_q[token_exp_q.size() - 1].last = 1'b1;
    endfunction

    function int pick_gap();
        if ($urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("token %0d: %s got %0h expected %0h", tokens_seen, what, got, want);
        error_count++;
    endtask

    task send_byte(input logic [7:0] c, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.char_byte <= c;
        char_bus.end_of_input <= e;
        predict_tokens(c, e);
        bytes_sent++;
        do
            @(posedge clk);
        while (!char_bus.ready);
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task wait_drained();
        char_bus.valid <= 1'b0;
        wait (token_exp_q.size() == 0);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        stt_pkg::tok_t exp_tok;
        if (tok_bus.valid && tok_bus.ready)
        begin
            if (token_exp_q.size() == 0)
            begin
                report_mismatch("unexpected token kind", tok_bus.token_kind, 0);
            end
            else
            begin
                exp_tok = token_exp_q.pop_front();
                if (tok_bus.token_kind != exp_tok.kind)
                    report_mismatch("kind", tok_bus.token_kind, exp_tok.kind);
                if (tok_bus.token_line != exp_tok.line)
                    report_mismatch("line", tok_bus.token_line, exp_tok.line);
                if (tok_bus.token_column != exp_tok.column)
                    report_mismatch("column", tok_bus.token_column, exp_tok.column);
                if (tok_bus.number_value != exp_tok.number_value)
                    report_mismatch("number", tok_bus.number_value, exp_tok.number_value);
                if (tok_bus.token_text != exp_tok.text)
                    report_mismatch("text", tok_bus.token_text, exp_tok.text);
                if (tok_bus.text_length != exp_tok.length)
                    report_mismatch("length", tok_bus.text_length, exp_tok.length);
                if (tok_bus.error_code != exp_tok.err)
                    report_mismatch("error", tok_bus.error_code, exp_tok.err);
                if (tok_bus.last_of_run != exp_tok.last)
                    report_mismatch("last", tok_bus.last_of_run, exp_tok.last);
            end
            tokens_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tok_bus.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            tok_bus.ready <= 1'b0;
            hold_cycles--;
        end
        else if (stall_left > 0)
        begin
            tok_bus.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            tok_bus.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    task test_directed();
        send_text("startprogram _AB _ _ABCDE longwordwithtail9 32768 -7 a:b :: x/y");
        send_text("\n+%!;,()* /* skip\n");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_text("or /* tail");
        send_byte(8'hA5, 1'b1);
        send_text("12");
        send_byte(8'h00, 1'b0);
        wait_drained();
    endtask

    task test_backpressure();
        wait (stall_left == 0);
        hold_cycles = 300;
        repeat (40) send_text("(:");
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task test_random();
        logic [7:0] lex[$];
        int         k;
        int         n;
        while (bytes_sent < 1250)
        begin
            lex.delete();
            case ($urandom_range(0, 13))
                0, 1:
                begin
                    k = $urandom_range(0, 15);
                    for (int i = 0; i < kw_names[k].len(); i++)
                        lex.insert(lex.size(), kw_names[k][i]);
                end
                2, 3:
                begin
                    lex.insert(lex.size(), 8'h5F);
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
                    repeat (n) lex.insert(lex.size(), 8'($urandom_range(8'h41, 8'h5A)));
                end
                4:
                begin
                    lex.insert(lex.size(), 8'($urandom_range(8'h61, 8'h7A)));
                    repeat ($urandom_range(0, 15))
                    begin
                        case ($urandom_range(0, 3))
                            0:       lex.insert(lex.size(), 8'($urandom_range(8'h41, 8'h5A)));
                            1:       lex.insert(lex.size(), 8'($urandom_range(8'h61, 8'h7A)));
                            2:       lex.insert(lex.size(), 8'($urandom_range(8'h30, 8'h39)));
                            default: lex.insert(lex.size(), 8'h5F);
                        endcase
                    end
                end
                5, 6:
                begin
                    repeat ($urandom_range(1, 7))
                        lex.insert(lex.size(), 8'($urandom_range(8'h30, 8'h39)));
                end
                7, 8:
                begin
                    case ($urandom_range(0, 11))
                        0:       lex.insert(lex.size(), 8'h2B);
                        1:       lex.insert(lex.size(), 8'h2D);
                        2:       lex.insert(lex.size(), 8'h2A);
                        3:       lex.insert(lex.size(), 8'h25);
                        4:       lex.insert(lex.size(), 8'h21);
                        5:       lex.insert(lex.size(), 8'h3B);
                        6:       lex.insert(lex.size(), 8'h2C);
                        7:       lex.insert(lex.size(), 8'h28);
                        8:       lex.insert(lex.size(), 8'h29);
                        9:       lex.insert(lex.size(), 8'h2F);
                        10:      lex.insert(lex.size(), 8'h3A);
                        default:
                        begin
                            lex.insert(lex.size(), 8'h3A);
                            lex.insert(lex.size(), 8'h3A);
                        end
                    endcase
                end
                9:
                begin
                    lex.insert(lex.size(), 8'h2F);
                    lex.insert(lex.size(), 8'h2A);
                    repeat ($urandom_range(0, 8))
                        lex.insert(lex.size(), 8'($urandom_range(1, 255)));
                    lex.insert(lex.size(), 8'h0A);
                end
                10:
                begin
                    lex.insert(lex.size(), 8'($urandom_range(0, 255)));
                end
                11:
                begin
                    lex.insert(lex.size(), 8'h0A);
                end
                default:
                begin
                end
            endcase
            if ($urandom_range(0, 2) != 0)
                lex.insert(lex.size(), $urandom_range(0, 1) ? 8'h20 : 8'h09);
            foreach (lex[i])
                send_byte(lex[i], 1'b0);
            if ($urandom_range(0, 60) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        char_bus.valid = 1'b0;
        char_bus.char_byte = 8'h00;
        char_bus.end_of_input = 1'b0;
        tok_bus.ready = 1'b0;
        error_count = 0;
        tokens_seen = 0;
        bytes_sent = 0;
        hold_cycles = 0;
        stall_left = 0;
        p_mode = stt_pkg::MODE_IDLE;
        p_line = 16'd1;
        p_col = 16'd1;
        p_start = 16'd1;
        p_wlen = 0;
        p_acc = 0;
        p_big = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes and checked %0d tokens, covering keywords, identifiers,",
                 bytes_sent, tokens_seen);
        $display("numbers with clamping, operators, comments, end of input and stalls.");
        if (error_count == 0 && token_exp_q.size() == 0)
        begin
            $display("source_text_tokenizer: match");
        end
        else
        begin
            $display("source_text_tokenizer: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
